[rtl/core/hrus_pkg.sv]
// ----------------------------------------------------------------------------
// hrus_pkg: shared types and constants for the unit scaler
// Level thresholds, divider constants, register indexes and mode codes.
// ----------------------------------------------------------------------------
`default_nettype none
package hrus_pkg;

	localparam int unsigned LEVELS = 5;
	localparam int unsigned CHUNKS = 5;

	localparam logic [26:0] K1000_RECIP = 27'd68719477;
	localparam logic [19:0] K10_RECIP   = 20'd838861;

	localparam logic [0:0] REG_UNIT_SYSTEM = 1'd0;
	localparam logic [0:0] REG_ROUND_MODE  = 1'd1;

	localparam logic [1:0] US_PLAIN = 2'd0;
	localparam logic [1:0] US_SI    = 2'd1;
	localparam logic [1:0] US_IEC   = 2'd2;

	localparam logic [1:0] RM_NEAREST = 2'd0;
	localparam logic [1:0] RM_UP      = 2'd1;
	localparam logic [1:0] RM_DOWN    = 2'd2;

	function automatic logic [63:0] thresh_of(input logic iec, input logic [2:0] lvl);
		logic [63:0] u;
		u = '0;
		case (lvl)
			3'd1:    u = iec ? 64'd1024             : 64'd1000;
			3'd2:    u = iec ? 64'd1048052          : 64'd999500;
			3'd3:    u = iec ? 64'd1073204954       : 64'd999500000;
			3'd4:    u = iec ? 64'd1098961871963    : 64'd999500000000;
			3'd5:    u = iec ? 64'd1125336956889203 : 64'd999500000000000;
			default: u = '0;
		endcase
		return u;
	endfunction

	// {quotient, remainder} of {rin, chunk} / 1000, rin below 1000
	function automatic logic [25:0] div1000_step(input logic [9:0] rin,
		input logic [15:0] chunk);
		logic [25:0] p;
		logic [52:0] prod;
		logic [15:0] q;
		logic [25:0] qd;
		p    = {rin, chunk};
		prod = {27'd0, p} * {26'd0, K1000_RECIP};
		q    = prod[51:36];
		qd   = {10'd0, q} * 26'd1000;
		return {q, 10'(p - qd)};
	endfunction

	// {quotient, remainder} of {rin, chunk} / 10, rin below 10
	function automatic logic [19:0] div10_step(input logic [3:0] rin,
		input logic [15:0] chunk);
		logic [19:0] p;
		logic [39:0] prod;
		logic [15:0] q;
		logic [19:0] qd;
		p    = {rin, chunk};
		prod = {20'd0, p} * {20'd0, K10_RECIP};
		q    = prod[38:23];
		qd   = {4'd0, q} * 20'd10;
		return {q, 4'(p - qd)};
	endfunction

	typedef struct packed {
		logic        neg;
		logic        si;
		logic        scaled;
		logic [1:0]  rmode;
		logic [2:0]  level;
	} ctl_t;

endpackage
`default_nettype wire

[rtl/core/hrus_div.sv]
// ----------------------------------------------------------------------------
// hrus_div: pipelined division by 1000
// Divides the working value by 1000 once per active round, 16 bits per stage,
// and tracks the nonzero and half flags of the total remainder.
// ----------------------------------------------------------------------------
`default_nettype none
module hrus_div (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	input  wire logic [79:0]          in_x,
	input  wire logic                 in_sticky,
	input  wire logic                 in_half,
	input  wire hrus_pkg::ctl_t       in_ctl,
	output logic                      out_valid,
	output logic [79:0]               out_x,
	output logic                      out_sticky,
	output logic                      out_half,
	output hrus_pkg::ctl_t            out_ctl
);
	localparam int unsigned NS = hrus_pkg::LEVELS * hrus_pkg::CHUNKS;

	logic            v_q   [NS];
	logic [79:0]     x_q   [NS];
	logic [9:0]      r_q   [NS];
	logic            s_q   [NS];
	logic            h_q   [NS];
	hrus_pkg::ctl_t  c_q   [NS];

	for (genvar k = 0; k < NS; k++) begin : g_st
		localparam int unsigned RND   = k / hrus_pkg::CHUNKS + 1;
		localparam int unsigned POS   = hrus_pkg::CHUNKS - 1 - k % hrus_pkg::CHUNKS;
		localparam bit          FIRST = (k % hrus_pkg::CHUNKS == 0);
		localparam bit          LAST  = (k % hrus_pkg::CHUNKS == hrus_pkg::CHUNKS - 1);

		logic           v_i;
		logic [79:0]    x_i;
		logic [9:0]     r_i;
		logic           s_i;
		logic           h_i;
		hrus_pkg::ctl_t c_i;
		logic           act;
		logic [9:0]     rin;
		logic [25:0]    qr;
		logic [79:0]    xn;
		logic [9:0]     rn;
		logic           sn;
		logic           hn;

		if (k == 0) begin : g_src
			assign v_i = in_valid;
			assign x_i = in_x;
			assign r_i = '0;
			assign s_i = in_sticky;
			assign h_i = in_half;
			assign c_i = in_ctl;
		end else begin : g_src
			assign v_i = v_q[k-1];
			assign x_i = x_q[k-1];
			assign r_i = r_q[k-1];
			assign s_i = s_q[k-1];
			assign h_i = h_q[k-1];
			assign c_i = c_q[k-1];
		end

		assign act = c_i.si && (c_i.level >= 3'(RND));
		assign rin = FIRST ? 10'd0 : r_i;
		assign qr  = hrus_pkg::div1000_step(rin, x_i[16*POS +: 16]);

		always_comb begin
			xn = x_i;
			rn = rin;
			sn = s_i;
			hn = h_i;
			if (act) begin
				xn[16*POS +: 16] = qr[25:10];
				rn = qr[9:0];
				if (LAST) begin
					sn = s_i || (qr[9:0] != 10'd0);
					hn = (qr[9:0] >= 10'd500);
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[k] <= 1'b0;
			end else begin
				v_q[k] <= v_i;
			end
		end
		always_ff @(posedge clk) begin
			x_q[k] <= xn;
			r_q[k] <= rn;
			s_q[k] <= sn;
			h_q[k] <= hn;
			c_q[k] <= c_i;
		end
	end

	assign out_valid  = v_q[NS-1];
	assign out_x      = x_q[NS-1];
	assign out_sticky = s_q[NS-1];
	assign out_half   = h_q[NS-1];
	assign out_ctl    = c_q[NS-1];

endmodule
`default_nettype wire

[rtl/core/human_readable_unit_scaler_unit.sv]
// ----------------------------------------------------------------------------
// human_readable_unit_scaler_unit: signed number to unit level and display value
// Picks K..P level, rounds the scaled magnitude to tenths, then to whole units from ten up.
// ----------------------------------------------------------------------------
//  channel | signals                                        | handshake
//  request | start, busy, value                             | start & !busy
//  result  | done, is_negative, unit_level, shown_value,    | done, one cycle
//          | has_tenth_digit                                |
//  config  | cfg_valid, cfg_ready, cfg_index, cfg_data      | valid & ready
//
// A request accepted on start passes 34 register stages before it shows on done;
// one request enters every cycle (busy is held low).
// The depth comes from five rounds of division by 1000 at 16 bits per stage
// (25 stages) and a four-stage division of the tenths by 10.
// Reset clears all valid bits and the registers to plain / nearest.
// The receiver cannot stall; results leave on done.
`default_nettype none
module human_readable_unit_scaler_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [63:0] value,
	output logic             done,
	output logic             is_negative,
	output logic [2:0]       unit_level,
	output logic [63:0]      shown_value,
	output logic             has_tenth_digit,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [0:0]  cfg_index,
	input  wire logic [1:0]  cfg_data
);
	localparam int unsigned WCH = 4;

	logic [1:0] unit_system_q, round_mode_q;

	assign cfg_ready = 1'b1;
	assign busy      = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_system_q <= hrus_pkg::US_PLAIN;
			round_mode_q  <= hrus_pkg::RM_NEAREST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				hrus_pkg::REG_UNIT_SYSTEM: unit_system_q <= cfg_data;
				hrus_pkg::REG_ROUND_MODE:  round_mode_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage 1: magnitude
	logic        v_s1, neg_s1;
	logic [63:0] m_s1;
	logic [1:0]  us_s1, rm_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else         v_s1 <= start && !busy;
	end
	always_ff @(posedge clk) begin
		neg_s1 <= value[63];
		m_s1   <= value[63] ? (~value + 64'd1) : value;
		us_s1  <= unit_system_q;
		rm_s1  <= round_mode_q;
	end

	// stage 2: level select
	logic        scl;
	logic        iec;
	logic [2:0]  lvl;
	always_comb begin
		iec = (us_s1 == hrus_pkg::US_IEC);
		scl = (us_s1 == hrus_pkg::US_SI) || iec;
		lvl = 3'd0;
		for (int i = 1; i <= int'(hrus_pkg::LEVELS); i++) begin
			if (m_s1 >= hrus_pkg::thresh_of(iec, 3'(i))) lvl = 3'(i);
		end
		if (!scl) lvl = 3'd0;
	end

	logic           v_s2;
	logic [63:0]    m_s2;
	hrus_pkg::ctl_t c_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else         v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		m_s2 <= m_s1;
		c_s2 <= '{neg: neg_s1, si: (us_s1 == hrus_pkg::US_SI), scaled: (lvl != 3'd0),
			rmode: rm_s1, level: lvl};
	end

	// stage 3: numerator m*10, binary units by shift
	logic [66:0] x10;
	logic [66:0] xi;
	logic        st;
	logic        hf;
	always_comb begin
		x10 = ({3'd0, m_s2} << 3) + ({3'd0, m_s2} << 1);
		xi  = x10;
		st  = 1'b0;
		hf  = 1'b0;
		case (c_s2.level)
			3'd1: begin xi = x10 >> 10; st = |x10[9:0];  hf = x10[9];  end
			3'd2: begin xi = x10 >> 20; st = |x10[19:0]; hf = x10[19]; end
			3'd3: begin xi = x10 >> 30; st = |x10[29:0]; hf = x10[29]; end
			3'd4: begin xi = x10 >> 40; st = |x10[39:0]; hf = x10[39]; end
			3'd5: begin xi = x10 >> 50; st = |x10[49:0]; hf = x10[49]; end
			default: ;
		endcase
	end

	logic           v_s3;
	logic [79:0]    x_s3;
	logic           st_s3;
	logic           hf_s3;
	hrus_pkg::ctl_t c_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else         v_s3 <= v_s2;
	end
	always_ff @(posedge clk) begin
		x_s3  <= !c_s2.scaled ? {16'd0, m_s2}
			: (c_s2.si ? {13'd0, x10} : {13'd0, xi});
		st_s3 <= c_s2.scaled && !c_s2.si && st;
		hf_s3 <= c_s2.scaled && !c_s2.si && hf;
		c_s3  <= c_s2;
	end

	logic           dv;
	logic [79:0]    dx;
	logic           ds, dh;
	hrus_pkg::ctl_t dc;

	hrus_div u_div (
		.clk(clk), .arst_n(arst_n),
		.in_valid(v_s3), .in_x(x_s3), .in_sticky(st_s3), .in_half(hf_s3), .in_ctl(c_s3),
		.out_valid(dv), .out_x(dx), .out_sticky(ds), .out_half(dh), .out_ctl(dc)
	);

	// stage 4: tenths rounding
	logic inc;
	always_comb begin
		case (dc.rmode)
			hrus_pkg::RM_UP:   inc = ds;
			hrus_pkg::RM_DOWN: inc = 1'b0;
			default:           inc = dh;
		endcase
	end

	logic           v_s4;
	logic [63:0]    t_s4;
	hrus_pkg::ctl_t c_s4;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else         v_s4 <= dv;
	end
	always_ff @(posedge clk) begin
		t_s4 <= (dc.scaled && inc) ? dx[63:0] + 64'd1 : dx[63:0];
		c_s4 <= dc;
	end

	// tenths by 10, 16 bits per stage
	logic           tv_q [WCH];
	logic [63:0]    tt_q [WCH];
	logic [63:0]    tq_q [WCH];
	logic [3:0]     tr_q [WCH];
	hrus_pkg::ctl_t tc_q [WCH];

	for (genvar k = 0; k < WCH; k++) begin : g_ten
		localparam int unsigned POS = WCH - 1 - k;

		logic           v_i;
		logic [63:0]    t_i;
		logic [63:0]    q_i;
		logic [3:0]     r_i;
		hrus_pkg::ctl_t c_i;
		logic [19:0]    qr;
		logic [63:0]    qn;

		if (k == 0) begin : g_src
			assign v_i = v_s4;
			assign t_i = t_s4;
			assign q_i = t_s4;
			assign r_i = '0;
			assign c_i = c_s4;
		end else begin : g_src
			assign v_i = tv_q[k-1];
			assign t_i = tt_q[k-1];
			assign q_i = tq_q[k-1];
			assign r_i = tr_q[k-1];
			assign c_i = tc_q[k-1];
		end

		assign qr = hrus_pkg::div10_step(r_i, q_i[16*POS +: 16]);

		always_comb begin
			qn = q_i;
			qn[16*POS +: 16] = qr[19:4];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) tv_q[k] <= 1'b0;
			else         tv_q[k] <= v_i;
		end
		always_ff @(posedge clk) begin
			tt_q[k] <= t_i;
			tq_q[k] <= qn;
			tr_q[k] <= qr[3:0];
			tc_q[k] <= c_i;
		end
	end

	// whole-unit rounding, halves to even
	logic [63:0] w;
	logic [3:0]  d;
	logic [63:0] shown;
	logic        tenth;
	always_comb begin
		w = tq_q[WCH-1];
		d = tr_q[WCH-1];
		tenth = 1'b0;
		shown = tt_q[WCH-1];
		if (tc_q[WCH-1].scaled) begin
			if (tt_q[WCH-1] >= 64'd100) begin
				shown = w + 64'((d > 4'd5) || (d == 4'd5 && w[0]));
			end else begin
				tenth = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else         done <= tv_q[WCH-1];
	end
	always_ff @(posedge clk) begin
		is_negative     <= tc_q[WCH-1].neg;
		unit_level      <= tc_q[WCH-1].level;
		shown_value     <= shown;
		has_tenth_digit <= tenth;
	end

	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> unit_level <= 3'd5) else $error("unit level out of range");
	a_tenth_small: assert property (@(posedge clk) disable iff (!arst_n)
		done && has_tenth_digit |-> shown_value < 64'd100) else $error("tenths too big");
	a_tenth_lvl: assert property (@(posedge clk) disable iff (!arst_n)
		done && has_tenth_digit |-> unit_level != 3'd0) else $error("tenths at level 0");

endmodule
`default_nettype wire
